@@ sv/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbp_pkg: shared types and constants for the tilt bubble block
// Angle table, fixed-point constants and controller/datapath command types.
// ----------------------------------------------------------------------------
package tbp_pkg;

   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 64;
   localparam int CORDIC_STEPS_DEF  = 16;

   localparam int TABLE_LEN = 24;
   // CORDIC working width: 16-bit sample << 14, plus gain growth and sign
   localparam int CW  = 36;
   // angle accumulator width, 1/32768 degree
   localparam int AW  = 25;

   localparam logic signed [AW-1:0] DEG90  = 25'sd2949120;
   localparam logic signed [AW-1:0] DEG180 = 25'sd5898240;
   localparam logic [29:0]          INV_GAIN = 30'd652032874;

   localparam int ROLL_LIM  = 23040;
   localparam int PITCH_LIM = 11520;

   localparam logic [1:0] CSR_DEAD_ZONE = 2'd0;
   localparam logic [1:0] CSR_DPP       = 2'd1;

   function automatic logic [21:0] atan_lut(input logic [4:0] i);
      logic [21:0] r;
      case (i)
         5'd0:  r = 22'd1474560;
         5'd1:  r = 22'd870484;
         5'd2:  r = 22'd459940;
         5'd3:  r = 22'd233473;
         5'd4:  r = 22'd117189;
         5'd5:  r = 22'd58652;
         5'd6:  r = 22'd29333;
         5'd7:  r = 22'd14667;
         5'd8:  r = 22'd7334;
         5'd9:  r = 22'd3667;
         5'd10: r = 22'd1833;
         5'd11: r = 22'd917;
         5'd12: r = 22'd458;
         5'd13: r = 22'd229;
         5'd14: r = 22'd115;
         5'd15: r = 22'd57;
         5'd16: r = 22'd29;
         5'd17: r = 22'd14;
         5'd18: r = 22'd7;
         5'd19: r = 22'd4;
         5'd20: r = 22'd2;
         5'd21: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic load;      // capture sample, start roll pass setup
      logic pre;       // special-case / pre-rotation of current pass
      logic iter;      // one CORDIC micro-rotation
      logic mag;       // gain multiply, first half
      logic mag2;      // gain multiply, second half; load pitch pass
      logic fin;       // round/clamp angles and compare
      logic div_start; // start bubble division
      logic div_step;  // one divider bit
      logic commit;    // store held angles and bubble, load output
   } tbp_cmd_type;

   typedef struct packed {
      logic special;   // pass resolved without iterating
      logic iter_done;
      logic pass_pitch;
      logic update;
      logic div_done;
   } tbp_sts_type;

endpackage

@@ sv/tbp_datapath.sv @@
// ----------------------------------------------------------------------------
// tbp_datapath: CORDIC vectoring, gain, angle compare and bubble division
// One shared CORDIC unit used for roll then pitch; restoring divider for
// the two bubble offsets.
// ----------------------------------------------------------------------------
module tbp_datapath #(
   parameter int SCREEN_WIDTH  = tbp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tbp_pkg::SCREEN_HEIGHT_DEF,
   parameter int CORDIC_STEPS  = tbp_pkg::CORDIC_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  tbp_pkg::tbp_cmd_type cmd,
   output tbp_pkg::tbp_sts_type sts,
   input  logic [47:0]         sample,
   input  logic [14:0]         dead_zone,
   input  logic [12:0]         dpp,
   output logic [15:0]         roll_out,
   output logic [14:0]         pitch_out,
   output logic [6:0]          bx_out,
   output logic [5:0]          by_out
);
   localparam int CW = tbp_pkg::CW;
   localparam int AW = tbp_pkg::AW;
   localparam int STEPS = (CORDIC_STEPS < tbp_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                                 : tbp_pkg::TABLE_LEN;
   localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);
   // centre plus a 15-bit quotient, signed
   localparam int PW = 18;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0] a_ff, a_in;
   logic [4:0]           i_ff, i_in;
   logic                 pass_ff, pass_in;   // 0 roll, 1 pitch
   logic signed [CW-1:0] ax_ff, ax_in;
   logic signed [AW-1:0] roll_a_ff, roll_a_in;
   logic                 spec_ff, spec_in;
   logic [65:0]          mlo_ff, mlo_in;     // x * low 15 bits of gain
   logic signed [15:0]   roll_ff, roll_in, hroll_ff, hroll_in;
   logic signed [15:0]   pitch_ff, pitch_in, hpitch_ff, hpitch_in;
   logic                 upd_ff, upd_in;
   // divider: two 15-bit magnitudes divided by dpp in parallel
   logic [14:0]          qr_ff, qr_in, qp_ff, qp_in;
   logic [12:0]          rr_ff, rr_in, rp_ff, rp_in;
   logic [3:0]           dc_ff, dc_in;
   logic [6:0]           bx_ff, bx_in;
   logic [5:0]           by_ff, by_in;

   logic signed [CW-1:0] sx, sy, sz, dx, dy;
   logic signed [CW+31:0] prod;
   logic signed [15:0]   ru, pu;
   logic signed [16:0]   dr, dp;
   logic [12:0]          dpv;
   logic [14:0]          ar, ap;
   logic [13:0]          tr, tp;
   logic signed [PW-1:0] px, py;

   function automatic logic signed [15:0] to_units(input logic signed [AW-1:0] a,
                                                   input int lim);
      logic signed [AW:0] q;
      q = (AW+1)'((a + (AW)'(128)) >>> 8);
      if (q > (AW+1)'(lim)) q = (AW+1)'(lim);
      if (q < -(AW+1)'(lim)) q = -(AW+1)'(lim);
      return q[15:0];
   endfunction

   assign sx = CW'($signed(sample[15:0])) <<< 14;
   assign sy = CW'($signed(sample[31:16])) <<< 14;
   assign sz = CW'($signed(sample[47:32])) <<< 14;
   assign dx = y_ff >>> i_ff;
   assign dy = x_ff >>> i_ff;
   assign prod = (CW+32)'($signed(mlo_ff))
               + ((CW+32)'(x_ff * $signed({1'b0, tbp_pkg::INV_GAIN[29:15]})) <<< 15)
               + (CW+32)'(1 <<< 29);
   assign ru = to_units(roll_a_ff, tbp_pkg::ROLL_LIM);
   assign pu = to_units(a_ff, tbp_pkg::PITCH_LIM);
   assign dr = 17'(ru) - 17'(hroll_ff);
   assign dp = 17'(pu) - 17'(hpitch_ff);
   assign dpv = (dpp == 13'd0) ? 13'd1 : dpp;
   assign ar = roll_ff[15] ? 15'(-roll_ff) : roll_ff[14:0];
   assign ap = pitch_ff[15] ? 15'(-pitch_ff) : pitch_ff[14:0];
   assign tr = {rr_ff, qr_ff[14]};
   assign tp = {rp_ff, qp_ff[14]};
   assign px = PW'(SCREEN_WIDTH / 2)
             + (roll_ff[15] ? -PW'(qr_ff) : PW'(qr_ff));
   assign py = PW'(SCREEN_HEIGHT / 2)
             + (pitch_ff[15] ? -PW'(qp_ff) : PW'(qp_ff));

   always_comb begin
      x_in = x_ff; y_in = y_ff; a_in = a_ff; i_in = i_ff; pass_in = pass_ff;
      ax_in = ax_ff; roll_a_in = roll_a_ff; spec_in = spec_ff; mlo_in = mlo_ff;
      roll_in = roll_ff; pitch_in = pitch_ff; hroll_in = hroll_ff;
      hpitch_in = hpitch_ff; upd_in = upd_ff; qr_in = qr_ff; qp_in = qp_ff;
      rr_in = rr_ff; rp_in = rp_ff; dc_in = dc_ff; bx_in = bx_ff; by_in = by_ff;
      if (cmd.load) begin
         x_in = sz; y_in = sy; ax_in = -sx; pass_in = 1'b0;
      end
      if (cmd.pre) begin
         i_in = 5'd0;
         spec_in = 1'b0;
         a_in = '0;
         if (y_ff == '0) begin
            spec_in = 1'b1;
            a_in = (x_ff < 0) ? tbp_pkg::DEG180 : '0;
            x_in = (x_ff < 0) ? -x_ff : x_ff;
         end else if (x_ff == '0) begin
            spec_in = 1'b1;
            a_in = (y_ff > 0) ? tbp_pkg::DEG90 : -tbp_pkg::DEG90;
            x_in = (y_ff > 0) ? y_ff : -y_ff;
         end else if (x_ff < 0) begin
            a_in = (y_ff > 0) ? tbp_pkg::DEG180 : -tbp_pkg::DEG180;
            x_in = -x_ff; y_in = -y_ff;
         end
      end
      if (cmd.iter) begin
         i_in = i_ff + 5'd1;
         if (y_ff > 0) begin
            x_in = x_ff + dx; y_in = y_ff - dy;
            a_in = a_ff + AW'(tbp_pkg::atan_lut(i_ff));
         end else begin
            x_in = x_ff - dx; y_in = y_ff + dy;
            a_in = a_ff - AW'(tbp_pkg::atan_lut(i_ff));
         end
      end
      if (cmd.mag) begin
         mlo_in = 66'(x_ff * $signed({1'b0, tbp_pkg::INV_GAIN[14:0]}));
      end
      if (cmd.mag2) begin
         // roll pass done: magnitude becomes the abscissa of pitch pass
         roll_a_in = a_ff;
         x_in = spec_ff ? x_ff : CW'(prod >>> 30);
         y_in = ax_ff;
         pass_in = 1'b1;
      end
      if (cmd.fin) begin
         roll_in = ru; pitch_in = pu;
         upd_in = ((dr < 0 ? -dr : dr) > 17'(dead_zone))
               || ((dp < 0 ? -dp : dp) > 17'(dead_zone));
      end
      if (cmd.div_start) begin
         qr_in = ar; qp_in = ap; rr_in = '0; rp_in = '0; dc_in = '0;
      end
      if (cmd.div_step) begin
         dc_in = dc_ff + 4'd1;
         if (tr >= 14'(dpv)) begin
            rr_in = 13'(tr - 14'(dpv)); qr_in = {qr_ff[13:0], 1'b1};
         end else begin
            rr_in = tr[12:0]; qr_in = {qr_ff[13:0], 1'b0};
         end
         if (tp >= 14'(dpv)) begin
            rp_in = 13'(tp - 14'(dpv)); qp_in = {qp_ff[13:0], 1'b1};
         end else begin
            rp_in = tp[12:0]; qp_in = {qp_ff[13:0], 1'b0};
         end
      end
      if (cmd.commit) begin
         hroll_in = roll_ff; hpitch_in = pitch_ff;
         if (px < PW'(2)) bx_in = 7'd2;
         else if (px > PW'(SCREEN_WIDTH - 3)) bx_in = 7'(SCREEN_WIDTH - 3);
         else bx_in = 7'(px);
         if (py < PW'(2)) by_in = 6'd2;
         else if (py > PW'(SCREEN_HEIGHT - 3)) by_in = 6'(SCREEN_HEIGHT - 3);
         else by_in = 6'(py);
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; a_ff <= a_in; i_ff <= i_in; pass_ff <= pass_in;
      ax_ff <= ax_in; roll_a_ff <= roll_a_in; spec_ff <= spec_in; mlo_ff <= mlo_in;
      roll_ff <= roll_in; pitch_ff <= pitch_in; upd_ff <= upd_in;
      qr_ff <= qr_in; qp_ff <= qp_in; rr_ff <= rr_in; rp_ff <= rp_in;
      dc_ff <= dc_in; bx_ff <= bx_in; by_ff <= by_in;
      if (reset) begin
         hroll_ff <= '0; hpitch_ff <= '0;
      end else begin
         hroll_ff <= hroll_in; hpitch_ff <= hpitch_in;
      end
   end

   assign sts.special    = spec_ff;
   assign sts.iter_done  = (i_ff == LAST_STEP);
   assign sts.pass_pitch = pass_ff;
   assign sts.update     = upd_ff;
   assign sts.div_done   = (dc_ff == 4'd15);
   assign roll_out  = roll_ff;
   assign pitch_out = pitch_ff[14:0];
   assign bx_out    = bx_ff;
   assign by_out    = by_ff;
endmodule

@@ sv/tbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbp_ctrl: sequencing controller for the tilt bubble block
// Walks two CORDIC passes, gain multiply, compare and division.
// ----------------------------------------------------------------------------
module tbp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 out_free,
   input  tbp_pkg::tbp_sts_type sts,
   output tbp_pkg::tbp_cmd_type cmd,
   output logic                 idle,
   output logic                 emit
);
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_PRE    = 9'b000000010,
      S_ITER   = 9'b000000100,
      S_MAG    = 9'b000001000,
      S_MAG2   = 9'b000010000,
      S_FIN    = 9'b000100000,
      S_DECIDE = 9'b001000000,
      S_DIV    = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      emit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1; state_in = S_PRE;
            end
         end
         S_PRE: begin
            cmd.pre = 1'b1; state_in = S_ITER;
         end
         S_ITER: begin
            if (sts.special) state_in = S_MAG;
            else begin
               cmd.iter = 1'b1;
               if (sts.iter_done) state_in = S_MAG;
            end
         end
         S_MAG: begin
            cmd.mag = 1'b1;
            state_in = sts.pass_pitch ? S_FIN : S_MAG2;
         end
         S_MAG2: begin
            cmd.mag2 = 1'b1; state_in = S_PRE;
         end
         S_FIN: begin
            cmd.fin = 1'b1; state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.update) begin
               cmd.div_start = 1'b1; state_in = S_DIV;
            end else state_in = S_IDLE;
         end
         S_DIV: begin
            if (sts.div_done) begin
               if (out_free) begin
                  cmd.commit = 1'b1; state_in = S_OUT;
               end
            end else cmd.div_step = 1'b1;
         end
         S_OUT: begin
            emit = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign idle = (state_ff == S_IDLE);
endmodule

@@ sv/tilt_bubble_position.sv @@
// ----------------------------------------------------------------------------
// tilt_bubble_position: accelerometer tilt to bubble level position
// Roll and pitch by CORDIC vectoring, dead-zone filter, bubble placement.
//
//   channel  dir  handshake            content
//   req_     in   tvalid/tready        accel x,y,z sample
//   rsp_     out  tvalid/tready        angles and bubble pixel
//   csr_     in   we                   dead_zone, degrees_per_pixel
//
// An updating item runs from one accepted request to the next through two
// passes on the shared CORDIC unit, the setup/gain/compare states, the 15
// divider steps plus commit, and the output state.
// Without an update the divide is skipped.
// A pass with a zero coordinate skips the CORDIC micro-rotations.
// Reset is synchronous; held angles clear to zero. One result is buffered
// in the output register; the next request is taken while it waits, and the
// commit of the following result stalls until it drains.
// ----------------------------------------------------------------------------
module tilt_bubble_position #(
   parameter int SCREEN_WIDTH  = tbp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tbp_pkg::SCREEN_HEIGHT_DEF,
   parameter int CORDIC_STEPS  = tbp_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x, accel_y, accel_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // roll_angle, pitch_angle, bubble_x, bubble_y, pad
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);
   tbp_pkg::tbp_cmd_type cmd;
   tbp_pkg::tbp_sts_type sts;
   logic        idle, emit, out_free;
   logic [47:0] sample_ff;
   logic [14:0] dz_ff;
   logic [12:0] dpp_ff;
   logic        ov_ff;
   logic [47:0] od_ff;
   logic [15:0] roll;
   logic [14:0] pitch;
   logic [6:0]  bx;
   logic [5:0]  by;

   assign req_tready = idle && !reset;
   assign out_free   = !ov_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) sample_ff <= req_tdata;
      if (reset) begin
         dz_ff <= 15'd128; dpp_ff <= 13'd256; ov_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == tbp_pkg::CSR_DEAD_ZONE) dz_ff <= csr_wdata;
         if (csr_we && csr_index == tbp_pkg::CSR_DPP) dpp_ff <= csr_wdata[12:0];
         if (emit) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
      end
      if (emit) od_ff <= {4'd0, by, bx, pitch, roll};
   end

   tbp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(req_tvalid), .out_free(out_free),
      .sts(sts), .cmd(cmd), .idle(idle), .emit(emit)
   );

   tbp_datapath #(
      .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .sample(cmd.load ? req_tdata : sample_ff), .dead_zone(dz_ff), .dpp(dpp_ff),
      .roll_out(roll), .pitch_out(pitch), .bx_out(bx), .by_out(by)
   );

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

`ifndef SYNTHESIS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> $past(out_free)) else $error("result emitted into full register");
   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
`endif
endmodule

@@ test/tilt_bubble_checker.sv @@
// ----------------------------------------------------------------------------
// tilt_bubble_checker: predicts and checks tilt bubble results
// Watches the request, response and register channels, works out roll,
// pitch and bubble position for each accepted request and compares every
// response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tilt_bubble_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   // lowest field last, so roll sits in the low bits
   typedef struct packed {
      logic [5:0]         by;
      logic [6:0]         bx;
      logic signed [14:0] pitch;
      logic signed [15:0] roll;
   } tilt_type;

   localparam longint ATAN [24] = '{
      1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
      7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0};

   tilt_type tilt_q[$];
   int       dead_zone, dpp, held_roll, held_pitch;

   // floor shift
   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   task automatic cordic_vector(input longint x0, input longint y0,
                                output longint ang, output longint mag);
      longint x, y, a, dx, dy;
      x = x0;
      y = y0;
      a = 0;
      if (y == 0) begin
         ang = (x < 0) ? 64'sd5898240 : 0;
         mag = (x < 0) ? -x : x;
         return;
      end
      if (x == 0) begin
         ang = (y > 0) ? 64'sd2949120 : -64'sd2949120;
         mag = (y > 0) ? y : -y;
         return;
      end
      if (x < 0) begin
         a = (y > 0) ? 64'sd5898240 : -64'sd5898240;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < tbp_pkg::CORDIC_STEPS_DEF && i < 24; i++) begin
         dx = asr(y, i);
         dy = asr(x, i);
         if (y > 0) begin
            x += dx; y -= dy; a += ATAN[i];
         end else begin
            x -= dx; y += dy; a -= ATAN[i];
         end
      end
      ang = a;
      mag = (x * 64'sd652032874 + (64'sd1 <<< 29)) >>> 30;
   endtask

   function automatic int to_deg128(longint a, int lim);
      longint q;
      q = (a + 128) >>> 8;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return int'(q);
   endfunction

   function automatic int bubble_pixel(int ang, int centre, int hi, int d);
      int p;
      p = centre + ang / ((d == 0) ? 1 : d);
      if (p < 2) p = 2;
      if (p > hi) p = hi;
      return p;
   endfunction

   task automatic predict_tilt(input logic [47:0] d);
      longint ax, ay, az, ra, rm, pa, pm;
      int roll, pitch, dr, dp;
      tilt_type t;
      ax = longint'($signed(d[15:0])) * 16384;
      ay = longint'($signed(d[31:16])) * 16384;
      az = longint'($signed(d[47:32])) * 16384;
      cordic_vector(az, ay, ra, rm);
      cordic_vector(rm, -ax, pa, pm);
      roll = to_deg128(ra, tbp_pkg::ROLL_LIM);
      pitch = to_deg128(pa, tbp_pkg::PITCH_LIM);
      dr = roll - held_roll;
      dp = pitch - held_pitch;
      if (dr < 0) dr = -dr;
      if (dp < 0) dp = -dp;
      if (!(dr > dead_zone || dp > dead_zone)) return;
      held_roll = roll;
      held_pitch = pitch;
      t.roll = roll[15:0];
      t.pitch = pitch[14:0];
      t.bx = 7'(bubble_pixel(roll, tbp_pkg::SCREEN_WIDTH_DEF / 2,
                             tbp_pkg::SCREEN_WIDTH_DEF - 3, dpp));
      t.by = 6'(bubble_pixel(pitch, tbp_pkg::SCREEN_HEIGHT_DEF / 2,
                             tbp_pkg::SCREEN_HEIGHT_DEF - 3, dpp));
      tilt_q.push_back(t);
   endtask

   always @(posedge clock) begin
      tilt_type e, g;
      if (reset) begin
         dead_zone = 128;
         dpp = 256;
         held_roll = 0;
         held_pitch = 0;
         fail_count = 0;
         tilt_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == tbp_pkg::CSR_DEAD_ZONE) dead_zone = int'(csr_wdata);
            else if (csr_index == tbp_pkg::CSR_DPP) dpp = int'(csr_wdata[12:0]);
         end
         if (req_tvalid && req_tready) predict_tilt(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            g = rsp_tdata[43:0];
            if (tilt_q.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               fail_count = fail_count + 1;
            end else begin
               e = tilt_q.pop_front();
               if (g.roll !== e.roll) begin
                  $error("roll_angle exp %0d got %0d", e.roll, g.roll);
                  fail_count = fail_count + 1;
               end
               if (g.pitch !== e.pitch) begin
                  $error("pitch_angle exp %0d got %0d", e.pitch, g.pitch);
                  fail_count = fail_count + 1;
               end
               if (g.bx !== e.bx) begin
                  $error("bubble_x exp %0d got %0d", e.bx, g.bx);
                  fail_count = fail_count + 1;
               end
               if (g.by !== e.by) begin
                  $error("bubble_y exp %0d got %0d", e.by, g.by);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending <= tilt_q.size();
   end
endmodule

@@ test/tb_tilt_bubble_position.sv @@
// ----------------------------------------------------------------------------
// tb_tilt_bubble_position: testbench top for the tilt bubble block
// Drives directed and random accelerometer samples under several register
// settings and idling patterns; the checker does the prediction.
// ----------------------------------------------------------------------------
module tb_tilt_bubble_position;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 0;
   logic [1:0]  csr_index = tbp_pkg::CSR_DEAD_ZONE;
   logic [14:0] csr_wdata = '0;
   int          fail_count, pending;
   int          send_idle = 0, recv_idle = 0;
   int          hold_cycles = 0;

   tilt_bubble_position dut (.*);
   tilt_bubble_checker chk (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {z, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [14:0] v);
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_run(input int n);
      for (int i = 0; i < n; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // axis extremes, zero ordinate/abscissa, negative abscissa, both zero
      send_sample(16'h0000, 16'h0000, 16'h4000);
      send_sample(16'h0000, 16'h0000, 16'hc000);
      send_sample(16'h0000, 16'h4000, 16'h0000);
      send_sample(16'h0000, 16'hc000, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h8000, 16'h0000, 16'h0000);
      send_sample(16'h7fff, 16'h0000, 16'h0000);
      send_sample(16'h1000, 16'h2000, 16'hd000);
      send_sample(16'hf000, 16'he000, 16'hd000);
      send_sample(16'hf000, 16'he000, 16'hd001);
      send_sample(16'hffff, 16'h0001, 16'h7fff);
      write_reg(tbp_pkg::CSR_DEAD_ZONE, 15'd0);
      write_reg(tbp_pkg::CSR_DPP, 15'd0);
      write_reg(2'd3, 15'h7fff);
      send_idle = 21; recv_idle = 85;
      random_run(150);
      write_reg(tbp_pkg::CSR_DEAD_ZONE, 15'd23040);
      write_reg(tbp_pkg::CSR_DPP, 15'd4096);
      random_run(100);
      write_reg(tbp_pkg::CSR_DEAD_ZONE, 15'h7fff);
      write_reg(tbp_pkg::CSR_DPP, 15'h1fff);
      random_run(30);
      write_reg(tbp_pkg::CSR_DEAD_ZONE, 15'd5);
      write_reg(tbp_pkg::CSR_DPP, 15'd1);
      send_idle = 85; recv_idle = 21;
      random_run(150);
      write_reg(tbp_pkg::CSR_DEAD_ZONE, 15'd128);
      write_reg(tbp_pkg::CSR_DPP, 15'd37);
      send_idle = 0; recv_idle = 0;
      hold_cycles <= 800;
      random_run(270);
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("** tilt_bubble_position: PASSED **");
      else $display("** tilt_bubble_position: FAILED **");
      $finish;
   end

   initial begin
      #4000000;
      $display("** tilt_bubble_position: FAILED **");
      $finish;
   end
endmodule

@@ tilt_bubble_position.f @@
sv/tbp_pkg.sv
sv/tbp_datapath.sv
sv/tbp_ctrl.sv
sv/tilt_bubble_position.sv
test/tilt_bubble_checker.sv
test/tb_tilt_bubble_position.sv
